FILE: src/fla_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and width helpers for the fit-policy free-list allocator.
// No dependencies.
package fla_pkg;

    localparam int ENTRIES   = 16;
    localparam int SIZE_BITS = 16;

    localparam int IDX_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_BITS  = $clog2(ENTRIES + 1);
    localparam int POS_BITS  = 4;
    localparam int FLD_BITS  = 16;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_FIRST = 2'd1,
        MODE_WORST = 2'd2,
        MODE_BEST  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_ALLOCATED = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_LOADED    = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        UPD_NONE   = 2'd0,
        UPD_LOAD   = 2'd1,
        UPD_SHRINK = 2'd2,
        UPD_REMOVE = 2'd3
    } upd_op_t;

    // best-so-far candidate passed down the cell row
    typedef struct packed {
        logic                 found;
        logic [IDX_BITS-1:0]  idx;
        logic [SIZE_BITS-1:0] val;
    } token_t;

    // list update broadcast to all cells
    typedef struct packed {
        upd_op_t              op;
        logic [IDX_BITS-1:0]  idx;
    } upd_cmd_t;

    function automatic logic [POS_BITS-1:0] to_pos(input logic [IDX_BITS-1:0] idx);
        logic [IDX_BITS+POS_BITS-1:0] w;
        w = {{POS_BITS{1'b0}}, idx};
        return w[POS_BITS-1:0];
    endfunction

    function automatic logic [FLD_BITS-1:0] to_fld(input logic [SIZE_BITS-1:0] v);
        logic [SIZE_BITS+FLD_BITS-1:0] w;
        w = {{FLD_BITS{1'b0}}, v};
        return w[FLD_BITS-1:0];
    endfunction

    function automatic logic [SIZE_BITS-1:0] from_fld(input logic [FLD_BITS-1:0] v);
        logic [SIZE_BITS+FLD_BITS-1:0] w;
        w = {{SIZE_BITS{1'b0}}, v};
        return w[SIZE_BITS-1:0];
    endfunction

endpackage

FILE: src/fla_cell.sv
`timescale 1ns / 1ps
// One list slot: holds a free block size, folds it into the passing candidate,
// and applies load / shrink / shift-up updates. Depends on fla_pkg.
module fla_cell import fla_pkg::*; (
    input  logic                 aclk,
    input  logic [IDX_BITS-1:0]  cell_idx,
    input  logic                 cell_valid,
    input  mode_t                mode,
    input  logic [SIZE_BITS-1:0] req,
    input  upd_cmd_t             cmd,
    input  logic [SIZE_BITS-1:0] nb_val,
    input  token_t               tok_in,
    output token_t               tok_out,
    output logic [SIZE_BITS-1:0] val_out
);

    logic [SIZE_BITS-1:0] val_reg, val_next;
    token_t               tok_reg, tok_next;
    logic                 fits;

    always_comb begin
        fits     = cell_valid && (val_reg >= req);
        tok_next = tok_in;
        if (fits) begin
            if (!tok_in.found) begin
                tok_next = '{found: 1'b1, idx: cell_idx, val: val_reg};
            end else if (mode == MODE_WORST && val_reg > tok_in.val) begin
                tok_next = '{found: 1'b1, idx: cell_idx, val: val_reg};
            end else if (mode == MODE_BEST && val_reg < tok_in.val) begin
                tok_next = '{found: 1'b1, idx: cell_idx, val: val_reg};
            end
        end
    end

    always_comb begin
        val_next = val_reg;
        case (cmd.op)
            UPD_LOAD: begin
                if (cmd.idx == cell_idx) val_next = req;
            end
            UPD_SHRINK: begin
                if (cmd.idx == cell_idx) val_next = val_reg - req;
            end
            UPD_REMOVE: begin
                // close the gap: everything at or after the removed slot moves up
                if (cell_idx >= cmd.idx) val_next = nb_val;
            end
            default: val_next = val_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
        tok_reg <= tok_next;
    end

    assign tok_out = tok_reg;
    assign val_out = val_reg;

endmodule

FILE: src/fit_policy_free_list_allocator.sv
`timescale 1ns / 1ps
// Top level of the fit-policy free-list allocator: control, entry count,
// row of fla_cell slots and result register. Depends on fla_pkg, fla_cell.
//
//  channel | ports                                        | direction
//  s_      | s_valid s_ready s_mode s_size s_request_id   | request in
//  m_      | m_valid m_ready m_status m_position          | result out
//          | m_granted_size m_leftover_size m_block_removed m_echo_id
//
// Load request steps: accept, update. Fit request steps: accept, scan, update;
// the candidate travels one cell per cycle down the row of ENTRIES cells.
// Reset empties the list (entry count to zero); slot contents need no reset.
// A result waiting on m_ready does not block the next request's search;
// only the final update step waits for the result register to free up.
module fit_policy_free_list_allocator import fla_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_mode,
    input  logic [FLD_BITS-1:0] s_size,
    input  logic [FLD_BITS-1:0] s_request_id,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_status,
    output logic [POS_BITS-1:0] m_position,
    output logic [FLD_BITS-1:0] m_granted_size,
    output logic [FLD_BITS-1:0] m_leftover_size,
    output logic                m_block_removed,
    output logic [FLD_BITS-1:0] m_echo_id
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t                state_reg, state_next;
    logic [IDX_BITS-1:0]   scan_cnt_reg, scan_cnt_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;

    mode_t                 mode_reg;
    logic [SIZE_BITS-1:0]  req_reg;
    logic [FLD_BITS-1:0]   id_reg;

    logic                  m_valid_reg, m_valid_next;
    status_t               status_reg, status_next;
    logic [POS_BITS-1:0]   pos_reg, pos_next;
    logic [FLD_BITS-1:0]   granted_reg, granted_next;
    logic [FLD_BITS-1:0]   left_reg, left_next;
    logic                  removed_reg, removed_next;
    logic [FLD_BITS-1:0]   echo_reg;

    token_t                tok [ENTRIES+1];
    logic [SIZE_BITS-1:0]  vals [ENTRIES];
    upd_cmd_t              cmd;
    logic                  accept, finish, out_free;
    logic [SIZE_BITS-1:0]  rest;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign finish   = (state_reg == S_DONE) && out_free;

    assign tok[0] = '0;

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        logic [SIZE_BITS-1:0] nb;
        if (i < ENTRIES - 1) begin : g_nb
            assign nb = vals[i+1];
        end else begin : g_last
            assign nb = '0;
        end
        fla_cell u_cell (
            .aclk       (aclk),
            .cell_idx   (IDX_BITS'(i)),
            .cell_valid (CNT_BITS'(i) < count_reg),
            .mode       (mode_reg),
            .req        (req_reg),
            .cmd        (cmd),
            .nb_val     (nb),
            .tok_in     (tok[i]),
            .tok_out    (tok[i+1]),
            .val_out    (vals[i])
        );
    end

    always_comb begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    scan_cnt_next = '0;
                    state_next    = (mode_t'(s_mode) == MODE_LOAD) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == IDX_BITS'(ENTRIES - 1)) state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // final step: decide the result and the list update
    always_comb begin
        cmd          = '{op: UPD_NONE, idx: '0};
        count_next   = count_reg;
        status_next  = ST_NO_SPACE;
        pos_next     = '0;
        granted_next = '0;
        left_next    = '0;
        removed_next = 1'b0;
        rest         = tok[ENTRIES].val - req_reg;
        if (mode_reg == MODE_LOAD) begin
            if (count_reg == CNT_BITS'(ENTRIES)) begin
                status_next = ST_FULL;
            end else begin
                status_next = ST_LOADED;
                pos_next    = to_pos(count_reg[IDX_BITS-1:0]);
                left_next   = to_fld(req_reg);
                cmd         = '{op: UPD_LOAD, idx: count_reg[IDX_BITS-1:0]};
                count_next  = count_reg + 1'b1;
            end
        end else if (tok[ENTRIES].found) begin
            status_next  = ST_ALLOCATED;
            pos_next     = to_pos(tok[ENTRIES].idx);
            granted_next = to_fld(req_reg);
            left_next    = to_fld(rest);
            if (rest == '0) begin
                removed_next = 1'b1;
                cmd          = '{op: UPD_REMOVE, idx: tok[ENTRIES].idx};
                count_next   = count_reg - 1'b1;
            end else begin
                cmd = '{op: UPD_SHRINK, idx: tok[ENTRIES].idx};
            end
        end
        if (!finish) begin
            cmd        = '{op: UPD_NONE, idx: '0};
            count_next = count_reg;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (finish)       m_valid_next = 1'b1;
        else if (m_ready) m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            scan_cnt_reg <= '0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            count_reg    <= count_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg <= mode_t'(s_mode);
            req_reg  <= from_fld(s_size);
            id_reg   <= s_request_id;
        end
        if (finish) begin
            status_reg  <= status_next;
            pos_reg     <= pos_next;
            granted_reg <= granted_next;
            left_reg    <= left_next;
            removed_reg <= removed_next;
            echo_reg    <= id_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_position      = pos_reg;
    assign m_granted_size  = granted_reg;
    assign m_leftover_size = left_reg;
    assign m_block_removed = removed_reg;
    assign m_echo_id       = echo_reg;

endmodule
